[hdl/assert_macros.svh]
// Assertion helpers used by the scheduler RTL. Each use names its own label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RRTS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[hdl/rrts_pkg.sv]
`default_nettype none
package rrts_pkg;

  localparam int unsigned MAX_THREADS = 128;

  localparam logic [2:0] ACT_SPAWN  = 3'd0;
  localparam logic [2:0] ACT_TERM   = 3'd1;
  localparam logic [2:0] ACT_BLOCK  = 3'd2;
  localparam logic [2:0] ACT_RESUME = 3'd3;
  localparam logic [2:0] ACT_SLEEP  = 3'd4;
  localparam logic [2:0] ACT_QEND   = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  thread_id;
    logic [15:0] sleep_quanta;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [6:0]  new_thread;
    logic [6:0]  running_thread;
    logic [31:0] thread_quanta;
    logic [31:0] total_quanta;
    logic        shutdown;
  } res_t;

  // Per-slot state carried around the slot ring.
  typedef struct packed {
    logic        in_use;
    logic        blocked;
    logic        sleeping;
    logic [15:0] sleep_left;
    logic [31:0] quanta;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } fifo_ctl_t;

endpackage
`default_nettype wire

[hdl/rrts_slot_cell.sv]
`default_nettype none
module rrts_slot_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           shift_i,
  input  rrts_pkg::slot_t     nb_i,
  output rrts_pkg::slot_t     q_o
);

  rrts_pkg::slot_t slot_q;

  // Slot zero comes out of reset in use with one quantum already counted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '{in_use: FIRST, blocked: 1'b0, sleeping: 1'b0, sleep_left: 16'd0,
                  quanta: {31'd0, FIRST}};
    end else if (shift_i) begin
      slot_q <= nb_i;
    end
  end

  assign q_o = slot_q;

endmodule
`default_nettype wire

[hdl/rrts_fifo_cell.sv]
`default_nettype none
module rrts_fifo_cell #(
  parameter int unsigned IDW = 7
) (
  input  wire logic                clk_i,
  input  rrts_pkg::fifo_ctl_t      ctl_i,
  input  wire logic [IDW-1:0]      wr_val_i,
  input  wire logic [IDW-1:0]      nb_i,
  output logic [IDW-1:0]           q_o
);

  logic [IDW-1:0] ent_q;

  // A direct write wins over the shift toward the head.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      ent_q <= wr_val_i;
    end else if (ctl_i.shift) begin
      ent_q <= nb_i;
    end
  end

  assign q_o = ent_q;

endmodule
`default_nettype wire

[hdl/round_robin_thread_scheduler.sv]
// Channel  | Ports                      | Handshake
// command  | start, cmd_i, busy         | taken at a rising edge with start high, busy low
// result   | done_o, res_o              | one-cycle strobe, always taken
//
// Every item takes one pass of the slot ring plus the S_ADEC and S_OUT control
// states. Removing a slot from the ready queue rotates the queue once, one
// queued entry at a time. A reschedule adds the S_POP state and a second ring
// pass, and a third pass when the queue is empty and no sleeper wakes.
// Reset is asynchronous and needs no clearing pass; the result side never stalls.
`default_nettype none
`include "assert_macros.svh"
module round_robin_thread_scheduler #(
  parameter int unsigned MAX_THREADS = rrts_pkg::MAX_THREADS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  rrts_pkg::cmd_t cmd_i,
  output logic           busy,
  output logic           done_o,
  output rrts_pkg::res_t res_o
);

  localparam int unsigned IDW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned CW  = $clog2(MAX_THREADS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PASSA  = 3'd1;
  localparam logic [2:0] S_ADEC   = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_PASSC  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]     state_q, state_d;
  rrts_pkg::cmd_t cmd_q, cmd_d;
  logic [IDW-1:0] idx_q, idx_d;
  logic [IDW-1:0] cur_q, cur_d;
  logic [31:0]    total_q, total_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  rot_q, rot_d;
  logic           ok_q, ok_d;
  logic           found_q, found_d;
  logic [IDW-1:0] new_q, new_d;
  logic           push_q, push_d;
  logic [IDW-1:0] push_id_q, push_id_d;
  logic           rem_q, rem_d;
  logic           resched_q, resched_d;
  logic           shut_q, shut_d;
  logic [31:0]    tq_q, tq_d;
  logic           have_q, have_d;
  logic           age_q, age_d;

  rrts_pkg::slot_t     slot_w [MAX_THREADS];
  rrts_pkg::slot_t     head, head_n;
  logic                ring_shift;
  logic [IDW-1:0]      fifo_w [MAX_THREADS];
  rrts_pkg::fifo_ctl_t fctl [MAX_THREADS];
  logic                fifo_shift, fifo_wr;
  logic [CW-1:0]       fifo_wr_pos;
  logic [IDW-1:0]      fifo_wr_val;

  logic           tid_ok, tid_hit, last, cnt_room, shutting;
  logic [IDW-1:0] tid_slot;

  assign head     = slot_w[0];
  assign tid_ok   = ({25'd0, cmd_q.thread_id} < 32'(MAX_THREADS));
  assign tid_slot = IDW'(cmd_q.thread_id);
  assign tid_hit  = tid_ok && (idx_q == tid_slot);
  assign last     = (idx_q == IDW'(MAX_THREADS - 1));
  assign cnt_room = (cnt_q < CW'(MAX_THREADS));
  assign shutting = (cmd_q.action == rrts_pkg::ACT_TERM) && (cmd_q.thread_id == 7'd0);
  assign ring_shift = (state_q == S_PASSA) || (state_q == S_PASSC);

  genvar k;
  generate
    for (k = 0; k < MAX_THREADS; k++) begin : g_cells
      rrts_pkg::slot_t slot_nb;
      logic [IDW-1:0]  fifo_nb;
      if (k == MAX_THREADS - 1) begin : g_tail
        assign slot_nb = head_n;
        assign fifo_nb = fifo_w[k];
      end else begin : g_body
        assign slot_nb = slot_w[k+1];
        assign fifo_nb = fifo_w[k+1];
      end

      rrts_slot_cell #(.FIRST(k == 0)) u_slot (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .nb_i    (slot_nb),
        .q_o     (slot_w[k])
      );

      assign fctl[k].shift = fifo_shift;
      assign fctl[k].wr    = fifo_wr && (fifo_wr_pos == CW'(k));

      rrts_fifo_cell #(.IDW(IDW)) u_fifo (
        .clk_i    (clk_i),
        .ctl_i    (fctl[k]),
        .wr_val_i (fifo_wr_val),
        .nb_i     (fifo_nb),
        .q_o      (fifo_w[k])
      );
    end
  endgenerate

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    rot_d       = rot_q;
    ok_d        = ok_q;
    found_d     = found_q;
    new_d       = new_q;
    push_d      = push_q;
    push_id_d   = push_id_q;
    rem_d       = rem_q;
    resched_d   = resched_q;
    shut_d      = shut_q;
    tq_d        = tq_q;
    have_d      = have_q;
    age_d       = age_q;
    head_n      = head;
    fifo_shift  = 1'b0;
    fifo_wr     = 1'b0;
    fifo_wr_pos = cnt_q;
    fifo_wr_val = idx_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d     = cmd_i;
          idx_d     = '0;
          ok_d      = (cmd_i.action == rrts_pkg::ACT_QEND);
          resched_d = (cmd_i.action == rrts_pkg::ACT_QEND);
          found_d   = 1'b0;
          new_d     = '0;
          push_d    = 1'b0;
          rem_d     = 1'b0;
          shut_d    = 1'b0;
          tq_d      = '0;
          state_d   = S_PASSA;
        end
      end

      S_PASSA: begin
        case (cmd_q.action)
          rrts_pkg::ACT_SPAWN: begin
            if (!found_q && !head.in_use) begin
              head_n        = '0;
              head_n.in_use = 1'b1;
              found_d       = 1'b1;
              new_d         = idx_q;
              ok_d          = 1'b1;
              push_d        = 1'b1;
              push_id_d     = idx_q;
            end
          end
          rrts_pkg::ACT_TERM: begin
            if (shutting) begin
              // Terminating slot zero puts every slot back to its reset value.
              head_n        = '0;
              head_n.in_use = (idx_q == '0);
              head_n.quanta = {31'd0, (idx_q == '0)};
              if (idx_q == '0) begin
                ok_d   = 1'b1;
                shut_d = 1'b1;
              end
            end else if (tid_hit && head.in_use) begin
              head_n    = '0;
              ok_d      = 1'b1;
              rem_d     = 1'b1;
              resched_d = (idx_q == cur_q);
            end
          end
          rrts_pkg::ACT_BLOCK: begin
            if (tid_hit && idx_q != '0 && head.in_use) begin
              ok_d = 1'b1;
              if (!head.blocked) begin
                head_n.blocked = 1'b1;
                if (!head.sleeping) begin
                  rem_d     = 1'b1;
                  resched_d = (idx_q == cur_q);
                end
              end
            end
          end
          rrts_pkg::ACT_RESUME: begin
            if (tid_hit && idx_q != '0 && head.in_use) begin
              ok_d = 1'b1;
              if (head.blocked) begin
                head_n.blocked = 1'b0;
                if (!head.sleeping) begin
                  push_d    = 1'b1;
                  push_id_d = idx_q;
                end
              end
            end
          end
          rrts_pkg::ACT_SLEEP: begin
            if (idx_q == cur_q && idx_q != '0 && cmd_q.sleep_quanta != 16'd0 &&
                head.in_use) begin
              head_n.sleeping   = 1'b1;
              head_n.sleep_left = cmd_q.sleep_quanta;
              ok_d              = 1'b1;
              resched_d         = 1'b1;
            end
          end
          rrts_pkg::ACT_QEND: begin
            if (idx_q == cur_q && head.in_use) begin
              push_d    = 1'b1;
              push_id_d = idx_q;
            end
          end
          default: begin
          end
        endcase
        if (tid_hit) begin
          tq_d = head_n.quanta;
        end
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) begin
          state_d = S_ADEC;
        end
      end

      S_ADEC: begin
        if (shut_q) begin
          cnt_d   = '0;
          cur_d   = '0;
          total_d = 32'd1;
          state_d = S_OUT;
        end else if (rem_q && cnt_q != '0) begin
          rot_d   = cnt_q;
          state_d = S_REMOVE;
        end else begin
          if (push_q && cnt_room) begin
            fifo_wr     = 1'b1;
            fifo_wr_val = push_id_q;
            cnt_d       = cnt_q + 1'b1;
          end
          state_d = resched_q ? S_POP : S_OUT;
        end
      end

      S_REMOVE: begin
        // Rotate the queue once, dropping every entry of the removed slot.
        fifo_shift = 1'b1;
        if (fifo_w[0] != tid_slot) begin
          fifo_wr     = 1'b1;
          fifo_wr_pos = cnt_q - 1'b1;
          fifo_wr_val = fifo_w[0];
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
        rot_d = rot_q - 1'b1;
        if (rot_q == CW'(1)) begin
          state_d = resched_q ? S_POP : S_OUT;
        end
      end

      S_POP: begin
        // The queue head runs next; an empty queue leaves it to the first waker.
        if (cnt_q != '0) begin
          fifo_shift = 1'b1;
          cnt_d      = cnt_q - 1'b1;
          cur_d      = fifo_w[0];
          have_d     = 1'b1;
        end else begin
          have_d = 1'b0;
        end
        age_d   = 1'b1;
        idx_d   = '0;
        state_d = S_PASSC;
      end

      S_PASSC: begin
        if (age_q && idx_q != '0 && head.sleeping) begin
          if (head.sleep_left == 16'd0) begin
            head_n.sleeping = 1'b0;
            if (!head.blocked) begin
              if (have_q) begin
                // The new runner has already left the queue, so one entry of
                // room stays reserved for it.
                if (cnt_q < CW'(MAX_THREADS - 1)) begin
                  fifo_wr = 1'b1;
                  cnt_d   = cnt_q + 1'b1;
                end
              end else begin
                cur_d  = idx_q;
                have_d = 1'b1;
              end
            end
          end else begin
            head_n.sleep_left = head.sleep_left - 1'b1;
          end
        end
        if (have_d && cur_d == idx_q && head_n.in_use) begin
          head_n.quanta = head_n.quanta + 32'd1;
        end
        if (tid_hit) begin
          tq_d = head_n.quanta;
        end
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) begin
          if (age_q && !have_d) begin
            // Nobody took over: one more pass to count the old slot's quantum.
            age_d  = 1'b0;
            have_d = 1'b1;
          end else begin
            total_d = total_q + 32'd1;
            state_d = S_OUT;
          end
        end
      end

      S_OUT: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      cur_q     <= '0;
      total_q   <= 32'd1;
      cnt_q     <= '0;
      rot_q     <= '0;
      ok_q      <= 1'b0;
      found_q   <= 1'b0;
      push_q    <= 1'b0;
      rem_q     <= 1'b0;
      resched_q <= 1'b0;
      shut_q    <= 1'b0;
      have_q    <= 1'b0;
      age_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      cnt_q     <= cnt_d;
      rot_q     <= rot_d;
      ok_q      <= ok_d;
      found_q   <= found_d;
      push_q    <= push_d;
      rem_q     <= rem_d;
      resched_q <= resched_d;
      shut_q    <= shut_d;
      have_q    <= have_d;
      age_q     <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    new_q     <= new_d;
    push_id_q <= push_id_d;
    tq_q      <= tq_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  assign res_o.status         = !ok_q;
  assign res_o.new_thread     = 7'(new_q);
  assign res_o.running_thread = 7'(cur_q);
  assign res_o.thread_quanta  = tq_q;
  assign res_o.total_quanta   = total_q;
  assign res_o.shutdown       = shut_q;

  `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `RRTS_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_THREADS))
  `RRTS_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `RRTS_ASSERT(a_shutdown_reset, done_o && res_o.shutdown,
               cur_q == '0 && total_q == 32'd1 && cnt_q == '0)

endmodule
`default_nettype wire

[tb/round_robin_thread_scheduler_checker.sv]
`default_nettype none
module round_robin_thread_scheduler_checker (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire logic      busy,
  input  rrts_pkg::cmd_t cmd_i,
  input  wire logic      done_o,
  input  rrts_pkg::res_t res_o,
  output int             fail_count,
  output int             pending
);

  logic [6:0]     ready_ring [rrts_pkg::MAX_THREADS];
  int unsigned    ready_len;
  bit             used [rrts_pkg::MAX_THREADS];
  bit             blocked [rrts_pkg::MAX_THREADS];
  bit             asleep [rrts_pkg::MAX_THREADS];
  logic [15:0]    nap_left [rrts_pkg::MAX_THREADS];
  logic [31:0]    slot_quanta [rrts_pkg::MAX_THREADS];
  logic [6:0]     running;
  logic [31:0]    quanta_sum;
  rrts_pkg::res_t sched_results [$];

  function automatic void sched_clear();
    for (int i = 0; i < rrts_pkg::MAX_THREADS; i++) begin
      ready_ring[i] = '0;
      used[i] = 1'b0;
      blocked[i] = 1'b0;
      asleep[i] = 1'b0;
      nap_left[i] = '0;
      slot_quanta[i] = '0;
    end
    ready_len = 0;
    used[0] = 1'b1;
    slot_quanta[0] = 32'd1;
    running = '0;
    quanta_sum = 32'd1;
  endfunction

  function automatic void ready_push(int slot);
    if (ready_len < rrts_pkg::MAX_THREADS) begin
      ready_ring[ready_len] = slot[6:0];
      ready_len++;
    end
  endfunction

  function automatic void ready_drop(int slot);
    int unsigned w;
    w = 0;
    for (int unsigned r = 0; r < ready_len; r++) begin
      if (ready_ring[r] != slot[6:0]) begin
        ready_ring[w] = ready_ring[r];
        w++;
      end
    end
    ready_len = w;
  endfunction

  // Ages the sleepers, then hands the processor to the head of the ready queue.
  function automatic void switch_thread();
    for (int i = 1; i < rrts_pkg::MAX_THREADS; i++) begin
      if (asleep[i]) begin
        if (nap_left[i] == 0) begin
          asleep[i] = 1'b0;
          if (!blocked[i]) ready_push(i);
        end else begin
          nap_left[i]--;
        end
      end
    end
    if (ready_len > 0) begin
      running = ready_ring[0];
      for (int unsigned k = 1; k < ready_len; k++) ready_ring[k-1] = ready_ring[k];
      ready_len--;
    end
    if (used[running]) slot_quanta[running]++;
    quanta_sum++;
  endfunction

  function automatic rrts_pkg::res_t sched_predict(rrts_pkg::cmd_t c);
    rrts_pkg::res_t r;
    int             tid;
    bit             live;
    tid = int'(c.thread_id);
    live = used[tid];
    r = '0;
    case (c.action)
      rrts_pkg::ACT_SPAWN: begin
        r.status = 1'b1;
        for (int i = 0; i < rrts_pkg::MAX_THREADS; i++) begin
          if (!used[i]) begin
            used[i] = 1'b1;
            blocked[i] = 1'b0;
            asleep[i] = 1'b0;
            nap_left[i] = '0;
            slot_quanta[i] = '0;
            ready_push(i);
            r.new_thread = i[6:0];
            r.status = 1'b0;
            break;
          end
        end
      end
      rrts_pkg::ACT_TERM: begin
        if (!live) begin
          r.status = 1'b1;
        end else if (tid == 0) begin
          sched_clear();
          r.shutdown = 1'b1;
        end else begin
          used[tid] = 1'b0;
          blocked[tid] = 1'b0;
          asleep[tid] = 1'b0;
          nap_left[tid] = '0;
          slot_quanta[tid] = '0;
          ready_drop(tid);
          if (tid == running) switch_thread();
        end
      end
      rrts_pkg::ACT_BLOCK: begin
        if (tid == 0 || !live) begin
          r.status = 1'b1;
        end else if (!blocked[tid]) begin
          blocked[tid] = 1'b1;
          if (!asleep[tid]) begin
            ready_drop(tid);
            if (tid == running) switch_thread();
          end
        end
      end
      rrts_pkg::ACT_RESUME: begin
        if (tid == 0 || !live) begin
          r.status = 1'b1;
        end else if (blocked[tid]) begin
          blocked[tid] = 1'b0;
          if (!asleep[tid]) ready_push(tid);
        end
      end
      rrts_pkg::ACT_SLEEP: begin
        if (running == 0 || c.sleep_quanta == 0 || !used[running]) begin
          r.status = 1'b1;
        end else begin
          asleep[running] = 1'b1;
          nap_left[running] = c.sleep_quanta;
          switch_thread();
        end
      end
      rrts_pkg::ACT_QEND: begin
        if (used[running]) ready_push(running);
        switch_thread();
      end
      default: r.status = 1'b1;
    endcase
    r.running_thread = running;
    r.thread_quanta = slot_quanta[tid];
    r.total_quanta = quanta_sum;
    return r;
  endfunction

  assign pending = sched_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rrts_pkg::res_t want;
    if (!rst_ni) begin
      sched_clear();
      sched_results.delete();
      fail_count <= 0;
    end else begin
      if (done_o) begin
        if (sched_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", res_o);
          fail_count <= fail_count + 1;
        end else begin
          want = sched_results.pop_front();
          if (res_o !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: status %0d/%0d new %0d/%0d run %0d/%0d",
                want.status, res_o.status, want.new_thread, res_o.new_thread,
                want.running_thread, res_o.running_thread);
              $display("  tq %0d/%0d total %0d/%0d shut %0d/%0d",
                want.thread_quanta, res_o.thread_quanta, want.total_quanta,
                res_o.total_quanta, want.shutdown, res_o.shutdown);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) sched_results.push_back(sched_predict(cmd_i));
    end
  end

endmodule
`default_nettype wire

[tb/round_robin_thread_scheduler_test.sv]
`default_nettype none
module round_robin_thread_scheduler_test;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  rrts_pkg::cmd_t cmd_i;
  logic           busy;
  logic           done_o;
  rrts_pkg::res_t res_o;
  int             fail_count;
  int             pending;

  round_robin_thread_scheduler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  round_robin_thread_scheduler_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic issue(logic [2:0] act, logic [6:0] tid, logic [15:0] naps);
    rrts_pkg::cmd_t c;
    int             gap;
    c.action = act;
    c.thread_id = tid;
    c.sleep_quanta = naps;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  task automatic random_command();
    int pick;
    logic [6:0]  tid;
    logic [15:0] naps;
    pick = $urandom_range(0, 99);
    tid = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(1, 12));
    case ($urandom_range(0, 9))
      0:       naps = 16'($urandom_range(0, 65535));
      1:       naps = 16'd0;
      default: naps = 16'($urandom_range(1, 4));
    endcase
    if (pick < 20)      issue(rrts_pkg::ACT_SPAWN, tid, naps);
    else if (pick < 29) issue(rrts_pkg::ACT_TERM,
                              ($urandom_range(0, 60) == 0) ? 7'd0 : tid, naps);
    else if (pick < 41) issue(rrts_pkg::ACT_BLOCK, tid, naps);
    else if (pick < 54) issue(rrts_pkg::ACT_RESUME, tid, naps);
    else if (pick < 68) issue(rrts_pkg::ACT_SLEEP, tid, naps);
    else if (pick < 97) issue(rrts_pkg::ACT_QEND, tid, naps);
    else                issue(3'($urandom_range(6, 7)), tid, naps);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(rrts_pkg::ACT_SPAWN, 7'd0, 16'd0);
    issue(rrts_pkg::ACT_QEND, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_SLEEP, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_SLEEP, 7'd1, 16'd1);
    issue(rrts_pkg::ACT_QEND, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_QEND, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_BLOCK, 7'd0, 16'd0);
    issue(rrts_pkg::ACT_RESUME, 7'd0, 16'd0);
    issue(rrts_pkg::ACT_TERM, 7'd127, 16'hFFFF);
    issue(rrts_pkg::ACT_BLOCK, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_BLOCK, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_RESUME, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_RESUME, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_SPAWN, 7'd0, 16'd0);
    issue(rrts_pkg::ACT_QEND, 7'd2, 16'd0);
    issue(rrts_pkg::ACT_SLEEP, 7'd2, 16'd3);
    issue(rrts_pkg::ACT_BLOCK, 7'd2, 16'd0);
    issue(rrts_pkg::ACT_RESUME, 7'd2, 16'd0);
    repeat (4) issue(rrts_pkg::ACT_QEND, 7'd2, 16'd0);
    issue(3'd6, 7'd1, 16'd0);
    issue(3'd7, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_TERM, 7'd1, 16'd0);
    issue(rrts_pkg::ACT_TERM, 7'd0, 16'd0);

    for (int n = 0; n < 600; n++) begin
      // Once, fill every slot so the table-full case and the top slot numbers occur.
      if (n == 300) repeat (130) issue(rrts_pkg::ACT_SPAWN, 7'($urandom_range(0, 127)), 16'd0);
      random_command();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/rrts_pkg.sv
hdl/rrts_slot_cell.sv
hdl/rrts_fifo_cell.sv
hdl/round_robin_thread_scheduler.sv
tb/round_robin_thread_scheduler_checker.sv
tb/round_robin_thread_scheduler_test.sv
